// ----- hdl/cdad_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdad_pkg
// Shared widths, calendar constants, types and month-length helpers for the
// calendar date shifter.
// ----------------------------------------------------------------------------
package cdad_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int OFF_W   = 21;
	// magnitude of the offset, up to 2^20, fits the offset width unsigned
	localparam int REM_W   = OFF_W;
	// year within the 400-year Gregorian cycle
	localparam int YOE_W   = 9;

	localparam logic [YEAR_W-1:0]  YEAR_MIN   = YEAR_W'(1);
	localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
	localparam logic [YEAR_W-1:0]  ERA_YEARS  = YEAR_W'(400);
	localparam logic [YOE_W-1:0]   YOE_LAST   = YOE_W'(399);
	localparam logic [YOE_W-1:0]   YOE_C100   = YOE_W'(100);
	localparam logic [YOE_W-1:0]   YOE_C200   = YOE_W'(200);
	localparam logic [YOE_W-1:0]   YOE_C300   = YOE_W'(300);

	localparam logic [MONTH_W-1:0] MON_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MON_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MON_APR = MONTH_W'(4);
	localparam logic [MONTH_W-1:0] MON_JUN = MONTH_W'(6);
	localparam logic [MONTH_W-1:0] MON_SEP = MONTH_W'(9);
	localparam logic [MONTH_W-1:0] MON_NOV = MONTH_W'(11);
	localparam logic [MONTH_W-1:0] MON_DEC = MONTH_W'(12);

	localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
	localparam logic [DAY_W-1:0]   DAY_28    = DAY_W'(28);
	localparam logic [DAY_W-1:0]   DAY_29    = DAY_W'(29);
	localparam logic [DAY_W-1:0]   DAY_30    = DAY_W'(30);
	localparam logic [DAY_W-1:0]   DAY_31    = DAY_W'(31);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_CHECK,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               bad_input;
		logic               year_overflow;
	} result_t;

	// leap year from the year within the 400-year cycle
	function automatic logic is_leap(input logic [YOE_W-1:0] yoe);
		return (yoe[1:0] == 2'b00) &&
			((yoe == '0) || ((yoe != YOE_C100) && (yoe != YOE_C200) && (yoe != YOE_C300)));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		if (m == MON_FEB) begin
			len = leap ? DAY_29 : DAY_28;
		end else if ((m == MON_APR) || (m == MON_JUN) || (m == MON_SEP) ||
				(m == MON_NOV)) begin
			len = DAY_30;
		end else begin
			len = DAY_31;
		end
		return len;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/cdad_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdad_if
// Valid/ready channels for the date shifter: start date with offset in,
// shifted date with status flags out.
// ----------------------------------------------------------------------------
interface cdad_req_if;
	import cdad_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [YEAR_W-1:0]       start_year;
	logic [MONTH_W-1:0]      start_month;
	logic [DAY_W-1:0]        start_day;
	logic signed [OFF_W-1:0] day_offset;

	modport source (output valid, start_year, start_month, start_day, day_offset,
		input ready);
	modport sink (input valid, start_year, start_month, start_day, day_offset,
		output ready);
endinterface

interface cdad_rsp_if;
	import cdad_pkg::*;

	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  result_year;
	logic [MONTH_W-1:0] result_month;
	logic [DAY_W-1:0]   result_day;
	logic               bad_input;
	logic               year_overflow;

	modport source (output valid, result_year, result_month, result_day, bad_input,
		year_overflow, input ready);
	modport sink (input valid, result_year, result_month, result_day, bad_input,
		year_overflow, output ready);
endinterface
`default_nettype wire

// ----- hdl/calendar_date_add_days_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_add_days_top
// Gregorian date shifted by a signed day offset, walked month by month.
// ----------------------------------------------------------------------------
// Usage: the req channel carries a start date (year, month, day) and a signed
// day offset; each transfer on req yields exactly one transfer on rsp with the
// shifted date, bad_input and year_overflow.
// Sequence: a load step, the year reduced modulo 400 (one subtract of 400
// per cycle), a check of the date, then the month walk, one month per cycle,
// and a hand-over to the output register. The month walk dominates, as its
// length grows with the offset: one month per 30.4 days on average.
// Throughput: one item at a time; req.ready is high only while the sequencer
// is idle, which it becomes as soon as the result moves to the output register.
// An invalid start date is echoed with bad_input set after the check cycle.
// Results before 0001-01-01 or after 9999-12-31 saturate and set year_overflow.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// A stalled receiver holds the output register; a finished result then waits
// in the sequencer and the next item is refused until the register frees up.
// ----------------------------------------------------------------------------
module calendar_date_add_days_top (
	input  wire logic clk,
	input  wire logic arst_n,
	cdad_req_if.sink   req,
	cdad_rsp_if.source rsp
);
	import cdad_pkg::*;

	logic    seq_idle;
	logic    seq_res_valid;
	logic    res_take;
	result_t seq_res;
	result_t res_q;
	logic    out_valid_q;

	// start the sequencer on every req transfer
	assign req.ready = seq_idle;

	cdad_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (req.valid && seq_idle),
		.start_year  (req.start_year),
		.start_month (req.start_month),
		.start_day   (req.start_day),
		.day_offset  (req.day_offset),
		.idle        (seq_idle),
		.res_valid   (seq_res_valid),
		.res_take    (res_take),
		.res         (seq_res)
	);

	// move the result across when the output register is empty or draining
	assign res_take = seq_res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload until the receiver takes it
	always_ff @(posedge clk) begin
		if (res_take) begin
			res_q <= seq_res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.result_year   = res_q.year;
	assign rsp.result_month  = res_q.month;
	assign rsp.result_day    = res_q.day;
	assign rsp.bad_input     = res_q.bad_input;
	assign rsp.year_overflow = res_q.year_overflow;
endmodule
`default_nettype wire

// ----- hdl/cdad_sub.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdad_sub
// Shared compare-and-subtract unit: difference and a less-than flag.
// ----------------------------------------------------------------------------
module cdad_sub (
	input  wire logic [cdad_pkg::REM_W-1:0] a,
	input  wire logic [cdad_pkg::REM_W-1:0] b,
	output logic [cdad_pkg::REM_W-1:0]      diff,
	output logic                            lt
);
	import cdad_pkg::*;

	logic [REM_W:0] wide;

	// borrow out of the top bit means a < b
	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[REM_W-1:0];
	assign lt   = wide[REM_W];
endmodule
`default_nettype wire

// ----- hdl/cdad_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdad_seq
// Sequencer and date registers: reduces the year modulo 400, checks the
// start date, then walks one month per cycle through the shared subtractor.
// ----------------------------------------------------------------------------
module cdad_seq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [cdad_pkg::YEAR_W-1:0]    start_year,
	input  wire logic [cdad_pkg::MONTH_W-1:0]   start_month,
	input  wire logic [cdad_pkg::DAY_W-1:0]     start_day,
	input  wire logic signed [cdad_pkg::OFF_W-1:0] day_offset,
	output logic                                idle,
	output logic                                res_valid,
	input  wire logic                           res_take,
	output cdad_pkg::result_t                   res
);
	import cdad_pkg::*;

	state_t state_q, state_nxt;

	logic [YEAR_W-1:0]  y_q;
	logic [MONTH_W-1:0] m_q;
	logic [DAY_W-1:0]   d_q;
	logic [REM_W-1:0]   r_q;
	logic               back_q;
	logic [YEAR_W-1:0]  yw_q;
	logic [YOE_W-1:0]   yoe_q;
	logic               bad_q;
	logic               ovf_q;

	logic [REM_W-1:0]   op_a, op_b, diff;
	logic               lt;
	logic [DAY_W-1:0]   len;
	logic [DAY_W:0]     gap;
	logic               date_ok;
	logic               sat;
	logic               walk_done;
	logic [MONTH_W-1:0] prev_m;
	logic [YEAR_W-1:0]  prev_y;
	logic [YOE_W-1:0]   prev_yoe;

	cdad_sub u_sub (
		.a    (op_a),
		.b    (op_b),
		.diff (diff),
		.lt   (lt)
	);

	assign len = month_len(m_q, is_leap(yoe_q));
	// days from the current day to the first of the next month
	assign gap = {1'b0, len} - {1'b0, d_q} + (DAY_W+1)'(1);

	assign date_ok = (y_q >= YEAR_MIN) && (y_q <= YEAR_MAX) &&
		(m_q >= MON_JAN) && (m_q <= MON_DEC) &&
		(d_q >= DAY_FIRST) && (d_q <= len);

	assign prev_m   = (m_q == MON_JAN) ? MON_DEC : m_q - MONTH_W'(1);
	assign prev_y   = (m_q == MON_JAN) ? y_q - YEAR_W'(1) : y_q;
	assign prev_yoe = (m_q != MON_JAN) ? yoe_q :
		((yoe_q == '0) ? YOE_LAST : yoe_q - YOE_W'(1));

	// stepping past the last or before the first representable month
	assign sat = !lt && (back_q ? ((m_q == MON_JAN) && (y_q == YEAR_MIN))
		: ((m_q == MON_DEC) && (y_q == YEAR_MAX)));
	assign walk_done = lt || sat;

	always_comb begin
		op_a = r_q;
		op_b = '0;
		unique case (state_q)
			ST_MOD: begin
				op_a = REM_W'(yw_q);
				op_b = REM_W'(ERA_YEARS);
			end
			ST_WALK: begin
				op_b = back_q ? REM_W'(d_q) : REM_W'(gap);
			end
			default: begin
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_nxt = ST_MOD;
			ST_MOD:    if (lt) state_nxt = ST_CHECK;
			ST_CHECK:  state_nxt = date_ok ? ST_WALK : ST_FINISH;
			ST_WALK:   if (walk_done) state_nxt = ST_FINISH;
			ST_FINISH: if (res_take) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		idle      = (state_q == ST_IDLE);
		res_valid = (state_q == ST_FINISH);
		res.year          = y_q;
		res.month         = m_q;
		res.day           = d_q;
		res.bad_input     = bad_q;
		res.year_overflow = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					y_q    <= start_year;
					m_q    <= start_month;
					d_q    <= start_day;
					yw_q   <= start_year;
					back_q <= day_offset[OFF_W-1];
					r_q    <= day_offset[OFF_W-1] ? REM_W'(~day_offset + 1'b1)
						: REM_W'(day_offset);
					bad_q  <= 1'b0;
					ovf_q  <= 1'b0;
				end
			end
			ST_MOD: begin
				if (lt) begin
					yoe_q <= yw_q[YOE_W-1:0];
				end else begin
					yw_q <= diff[YEAR_W-1:0];
				end
			end
			ST_CHECK: begin
				if (!date_ok) begin
					bad_q <= 1'b1;
				end
			end
			ST_WALK: begin
				if (!back_q) begin
					if (lt) begin
						d_q <= d_q + r_q[DAY_W-1:0];
					end else if (sat) begin
						d_q   <= DAY_31;
						ovf_q <= 1'b1;
					end else begin
						r_q <= diff;
						d_q <= DAY_FIRST;
						if (m_q == MON_DEC) begin
							m_q   <= MON_JAN;
							y_q   <= y_q + YEAR_W'(1);
							yoe_q <= (yoe_q == YOE_LAST) ? '0 : yoe_q + YOE_W'(1);
						end else begin
							m_q <= m_q + MONTH_W'(1);
						end
					end
				end else begin
					if (lt) begin
						d_q <= d_q - r_q[DAY_W-1:0];
					end else if (sat) begin
						d_q   <= DAY_FIRST;
						ovf_q <= 1'b1;
					end else begin
						r_q   <= diff;
						m_q   <= prev_m;
						y_q   <= prev_y;
						yoe_q <= prev_yoe;
						d_q   <= month_len(prev_m, is_leap(prev_yoe));
					end
				end
			end
			ST_FINISH: begin
				r_q <= r_q;
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- dv/calendar_date_add_days_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_days_top_tb
// Self-checking bench for the date shifter: directed dates around leap years,
// month and year wrap, saturation at both ends, full-scale offsets and invalid
// start dates, then random dates under changing idle patterns on both sides.
// Each request transfer queues a predicted result, and each response transfer
// is checked field by field against the oldest one in the queue.
// ----------------------------------------------------------------------------
module calendar_date_add_days_top_tb;
	import cdad_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 5;
	// A full-scale offset walks about 34,500 months; allow several times that.
	localparam int WATCHDOG_LIMIT = 200000;
	// Cycles to watch for stray responses once the queue has drained.
	localparam int SETTLE_CYCLES  = 100;
	// Long receiver hold-off that fills the output register and the sequencer.
	localparam int HOLD_CYCLES    = 500;

	logic clk = 1'b0;
	logic arst_n;

	cdad_req_if date_req ();
	cdad_rsp_if date_rsp ();

	calendar_date_add_days_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (date_req),
		.rsp    (date_rsp)
	);

	// Predicted results, oldest first.
	result_t expected_dates[$];
	int      mismatches = 0;

	// Idle rates, in cycles of a hundred, for each side.
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;

	// Hold-off requests: the test side bumps hold_asked, the receiver serves it.
	int hold_asked  = 0;
	int hold_served = 0;
	int hold_left   = 0;

	int idle_cycles = 0;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Calendar predictor. Dates are turned into a day count from a March-based
	// year (so February's extra day falls at the end of the count year), the
	// offset is added, the count is clamped to 0001-01-01 .. 9999-12-31 and
	// turned back into a date.
	// ------------------------------------------------------------------------
	function automatic bit leap_year(input longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic longint days_in_month(input longint y, input longint m);
		case (m)
			2:             return leap_year(y) ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	// Only for valid dates with year of at least 1, so nothing here goes negative.
	function automatic longint day_count(input longint y, input longint m,
			input longint d);
		longint yy, cycle, yoc, mar_month, doy, doc;
		yy        = (m <= 2) ? y - 1 : y;
		cycle     = yy / 400;
		yoc       = yy - cycle * 400;
		mar_month = (m > 2) ? m - 3 : m + 9;
		doy       = (153 * mar_month + 2) / 5 + d - 1;
		doc       = yoc * 365 + yoc / 4 - yoc / 100 + doy;
		return cycle * 146097 + doc;
	endfunction

	function automatic result_t shift_date(input logic [YEAR_W-1:0] y,
			input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
			input logic signed [OFF_W-1:0] off);
		result_t r;
		longint  first_day, last_day, target;
		longint  cycle, doc, yoc, doy, mar_month, rd, rm, ry;
		r = '0;
		if ((y < YEAR_MIN) || (y > YEAR_MAX) || (m < MON_JAN) || (m > MON_DEC) ||
				(d == 0) || (d > days_in_month(y, m))) begin
			// Echo the start date untouched.
			r.year      = y;
			r.month     = m;
			r.day       = d;
			r.bad_input = 1'b1;
			return r;
		end
		first_day = day_count(1, 1, 1);
		last_day  = day_count(9999, 12, 31);
		target    = day_count(y, m, d) + longint'(off);
		if (target < first_day) begin
			target          = first_day;
			r.year_overflow = 1'b1;
		end else if (target > last_day) begin
			target          = last_day;
			r.year_overflow = 1'b1;
		end
		cycle     = target / 146097;
		doc       = target - cycle * 146097;
		yoc       = (doc - doc / 1460 + doc / 36524 - doc / 146096) / 365;
		doy       = doc - (365 * yoc + yoc / 4 - yoc / 100);
		mar_month = (5 * doy + 2) / 153;
		rd        = doy - (153 * mar_month + 2) / 5 + 1;
		rm        = (mar_month < 10) ? mar_month + 3 : mar_month - 9;
		ry        = yoc + cycle * 400 + ((rm <= 2) ? 1 : 0);
		r.year    = YEAR_W'(ry);
		r.month   = MONTH_W'(rm);
		r.day     = DAY_W'(rd);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Response side: ready pattern, with a long hold-off whenever one is asked
	// for. The hold-off is counted here so it runs regardless of the sender.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			date_rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			date_rsp.ready <= 1'b0;
		end else if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left   = HOLD_CYCLES - 1;
			date_rsp.ready <= 1'b0;
		end else begin
			date_rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	function automatic bit field_differs(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Check every response transfer against the oldest prediction.
	always @(posedge clk) begin : check_response
		result_t want;
		bit      bad;
		if (arst_n && date_rsp.valid && date_rsp.ready) begin
			if (expected_dates.size() == 0) begin
				$display("%0t ns: response with nothing expected, got %0d-%0d-%0d", $time,
					date_rsp.result_year, date_rsp.result_month, date_rsp.result_day);
				mismatches++;
			end else begin
				want = expected_dates.pop_front();
				bad  = 1'b0;
				bad |= field_differs("result_year", want.year, date_rsp.result_year);
				bad |= field_differs("result_month", want.month, date_rsp.result_month);
				bad |= field_differs("result_day", want.day, date_rsp.result_day);
				bad |= field_differs("bad_input", want.bad_input, date_rsp.bad_input);
				bad |= field_differs("year_overflow", want.year_overflow,
					date_rsp.year_overflow);
				if (bad)
					mismatches++;
			end
		end
	end

	// Stop the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((date_req.valid && date_req.ready) || (date_rsp.valid && date_rsp.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAIL calendar_date_add_days_top");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Request side. Call at a rising edge; returns at the edge of the transfer
	// with valid still high, so a following call can keep it high without a
	// drop. Idle cycles are inserted before the item at the current rate.
	// ------------------------------------------------------------------------
	task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
			input logic [DAY_W-1:0] d, input logic signed [OFF_W-1:0] off);
		while ($urandom_range(99) < snd_idle_pct) begin
			date_req.valid <= 1'b0;
			@(posedge clk);
		end
		date_req.valid       <= 1'b1;
		date_req.start_year  <= y;
		date_req.start_month <= m;
		date_req.start_day   <= d;
		date_req.day_offset  <= off;
		@(posedge clk);
		while (!date_req.ready)
			@(posedge clk);
		expected_dates.push_back(shift_date(y, m, d, off));
	endtask

	// Drop valid and hold off until every predicted result has been seen.
	task automatic wait_drained;
		date_req.valid <= 1'b0;
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random offset: mostly short walks, some long, a few full scale.
	function automatic logic signed [OFF_W-1:0] random_offset;
		int unsigned pick, mag;
		pick = $urandom_range(99);
		if (pick < 60)
			mag = $urandom_range(400);
		else if (pick < 88)
			mag = $urandom_range(5000);
		else if (pick < 97)
			mag = $urandom_range(60000);
		else
			mag = $urandom_range(1048575);
		return $urandom_range(1) ? -OFF_W'(mag) : OFF_W'(mag);
	endfunction

	task automatic random_date(output logic [YEAR_W-1:0] y, output logic [MONTH_W-1:0] m,
			output logic [DAY_W-1:0] d, output logic signed [OFF_W-1:0] off);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			// Noise: any field pattern, mostly invalid, short offset.
			y   = YEAR_W'($urandom_range(16383));
			m   = MONTH_W'($urandom_range(15));
			d   = DAY_W'($urandom_range(31));
			off = OFF_W'($urandom_range(2000)) - OFF_W'(1000);
			return;
		end
		if (pick < 25)
			y = $urandom_range(1) ? YEAR_W'($urandom_range(3, 1)) :
				YEAR_W'($urandom_range(9999, 9997));
		else
			y = YEAR_W'($urandom_range(9999, 1));
		m = MONTH_W'($urandom_range(12, 1));
		if ($urandom_range(4) == 0)
			d = DAY_W'(days_in_month(y, m));
		else
			d = DAY_W'($urandom_range(days_in_month(y, m), 1));
		off = random_offset();
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_leap_rules;
		send_date(2024, 2, 28, 1);      // into the leap day
		send_date(2023, 2, 28, 1);      // common year skips to March
		send_date(1900, 2, 28, 1);      // century year is common
		send_date(2000, 2, 29, 0);      // zero offset on a leap day of a 400th year
		send_date(2000, 3, 1, -1);      // back onto the leap day
		wait_drained();
	endtask

	task automatic test_year_wrap;
		send_date(1999, 12, 31, 1);
		send_date(2000, 1, 1, -1);
		wait_drained();
	endtask

	task automatic test_saturation;
		send_date(1, 1, 1, -1);
		send_date(9999, 12, 31, 1);
		send_date(1, 1, 1, -21'sd1048576);
		send_date(9999, 12, 31, 21'sd1048575);
		wait_drained();
	endtask

	task automatic test_full_scale;
		send_date(5000, 6, 15, 21'sd1048575);
		send_date(5000, 6, 15, -21'sd1048576);
		send_date(1, 1, 1, 21'sd1048575);
		send_date(9999, 12, 31, -21'sd1048576);
		wait_drained();
	endtask

	task automatic test_invalid_dates;
		send_date(0, 6, 15, 100);                   // year below range
		send_date(16383, 15, 31, -1);               // every field bit set
		send_date(10000, 1, 1, 5);                  // year above range
		send_date(2020, 0, 10, 3);                  // month zero
		send_date(2020, 13, 1, -3);                 // month past December
		send_date(2020, 4, 31, 1);                  // day past a 30-day month
		send_date(2020, 6, 0, -21'sd1048576);       // day zero
		send_date(2023, 2, 29, 1);                  // leap day in a common year
		send_date(2024, 2, 30, 1);                  // past the leap day
		send_date(1900, 2, 29, 1);                  // leap day in a century year
		wait_drained();
	endtask

	// Stall the receiver for a long stretch while short items keep coming, so
	// the output register fills, a second result waits in the sequencer and
	// the request side is refused until the stall ends.
	task automatic test_output_stall;
		logic [YEAR_W-1:0]       y;
		logic [MONTH_W-1:0]      m;
		logic [DAY_W-1:0]        d;
		logic signed [OFF_W-1:0] off;
		snd_idle_pct = 0;
		hold_asked++;
		repeat (6) begin
			random_date(y, m, d, off);
			send_date(y, m, d, OFF_W'($urandom_range(80)) - OFF_W'(40));
		end
		wait_drained();
	endtask

	task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
		logic [YEAR_W-1:0]       y;
		logic [MONTH_W-1:0]      m;
		logic [DAY_W-1:0]        d;
		logic signed [OFF_W-1:0] off;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		repeat (count) begin
			random_date(y, m, d, off);
			send_date(y, m, d, off);
		end
		wait_drained();
	endtask

	initial begin
		arst_n               = 1'b0;
		date_req.valid       = 1'b0;
		date_req.start_year  = '0;
		date_req.start_month = '0;
		date_req.start_day   = '0;
		date_req.day_offset  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the first idle pattern.
		snd_idle_pct = 37;
		rcv_idle_pct = 81;
		test_leap_rules();
		test_year_wrap();
		test_saturation();
		test_full_scale();
		test_invalid_dates();

		test_random(23, 37, 81);
		test_output_stall();
		test_random(23, 81, 37);
		test_random(23, 0, 0);

		if (mismatches == 0)
			$display("PASS calendar_date_add_days_top");
		else
			$display("FAIL calendar_date_add_days_top");
		$finish;
	end

endmodule
